// File: rtl/ttp_pkg.sv
`default_nettype none

package ttp_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLED   = 3'd0;
    localparam logic [2:0] CFG_BASE_STEP = 3'd1;
    localparam logic [2:0] CFG_FAST_GAIN = 3'd2;
    localparam logic [2:0] CFG_SLOW_GAIN = 3'd3;
    localparam logic [2:0] CFG_LEVEL_KEEP = 3'd4;
    localparam logic [2:0] CFG_MATCH_KEEP = 3'd5;
    localparam logic [2:0] CFG_LOUD_FLOOR = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Quarter-wave sine polynomial coefficients, Q.30
    localparam logic [31:0] SIN_A = 32'd1686629713;
    localparam logic [31:0] SIN_B = 32'd688904866;
    localparam logic [31:0] SIN_C = 32'd76016977;

    // round(2^32 / pi)
    localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;

    // Normalized sample clip, Q.16
    localparam logic [31:0] HELD_LIMIT = 32'd4194304;

    // Result field widths
    localparam int SINE_W  = 16;
    localparam int TURN_W  = 32;
    localparam int LOCK_W  = 16;

    // Reset values of the retention and floor registers
    localparam logic [15:0] KEEP_RESET  = 16'd65471;
    localparam logic [15:0] FLOOR_RESET = 16'd1;

endpackage

`default_nettype wire

// File: rtl/ttp_in_if.sv
`default_nettype none

interface ttp_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// File: rtl/ttp_out_if.sv
`default_nettype none

interface ttp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] local_sine;
    logic        [31:0] phase_out;
    logic signed [31:0] increment_out;
    logic        [15:0] lock_quality;

    modport source (output valid, output local_sine, output phase_out,
                    output increment_out, output lock_quality, input ready);
    modport sink   (input valid, input local_sine, input phase_out,
                    input increment_out, input lock_quality, output ready);
endinterface

`default_nettype wire

// File: rtl/tone_tracking_pll_top.sv
`default_nettype none

// Second-order tone-tracking PLL. One sample transfer in gives one result
// transfer out. All arithmetic runs through one registered 33x33 signed
// multiplier driven by a step sequencer, with a one-bit-per-cycle square
// root and a restoring divider in between. An enabled item passes the
// sine, root, divide and post steps before its result is ready for
// transfer; a disabled item skips them. The input is not ready while an item
// is in work, and a finished result is held in an output register so the
// next sample may be taken while that result waits.
module tone_tracking_pll_top
    import ttp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int PHASE_WIDTH  = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    ttp_in_if.sink               i_smp,
    ttp_out_if.source            o_res
);

    localparam int EXT_W = 48;
    localparam int SHR   = (SAMPLE_WIDTH >= 16) ? SAMPLE_WIDTH - 16 : 0;
    localparam int SHL   = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;
    localparam int PH_LO = TURN_W - PHASE_WIDTH;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PRE  = 6'b000010,
        S_ROOT = 6'b000100,
        S_DIV  = 6'b001000,
        S_POST = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        logic signed [43:0] hi;
        logic signed [43:0] lo;
        hi = 44'sd2147483647;
        lo = -44'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // Control and configuration
    t_state r_state, n_state;
    logic [3:0]  r_pc, n_pc;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_enabled;
    logic [30:0] r_base_step;
    logic [31:0] r_fast_gain, r_slow_gain;
    logic [15:0] r_level_keep, r_match_keep, r_loud_floor;

    // Loop state
    logic [PHASE_WIDTH-1:0] r_phase, n_phase;
    logic signed [31:0] r_integ, n_integ;
    logic        [31:0] r_loud, n_loud;
    logic signed [31:0] r_match, n_match;

    // Working registers
    logic signed [15:0] r_s, n_s;
    logic        [30:0] r_x, n_x, r_x2, n_x2;
    logic signed [15:0] r_mine, n_mine, r_across, n_across;
    logic signed [65:0] r_prod, r_acc, n_acc;
    logic        [34:0] r_sv, n_sv, r_res, n_res, r_bit, n_bit;
    logic        [17:0] r_rem, n_rem, r_dvs, n_dvs;
    logic        [31:0] r_dq, n_dq;
    logic signed [23:0] r_held, n_held;
    logic               r_neg, n_neg;
    logic        [36:0] r_mag, n_mag, r_e, n_e;
    logic signed [31:0] r_xm, n_xm;
    logic        [41:0] r_ti, n_ti, r_tf, n_tf;
    logic signed [31:0] r_inc, n_inc;

    // Pending result and output register
    logic signed [15:0] r_p_sine, n_p_sine;
    logic        [31:0] r_p_phase, n_p_phase;
    logic signed [31:0] r_p_inc, n_p_inc;
    logic        [15:0] r_p_lock, n_p_lock;
    logic               r_ov;
    logic signed [15:0] r_o_sine;
    logic        [31:0] r_o_phase;
    logic signed [31:0] r_o_inc;
    logic        [15:0] r_o_lock;

    // Shared multiplier operands
    logic signed [32:0] mul_a, mul_b;

    // Combinational helpers
    logic signed [EXT_W-1:0] smp_ext, smp_al;
    logic        [31:0] ang;
    logic        [1:0]  quad;
    logic        [30:0] xf;
    logic        [32:0] y_rnd;
    logic        [17:0] y_q;
    logic        [14:0] y_clip;
    logic signed [15:0] y_sgn;
    logic        [34:0] rt_try;
    logic               rt_ge;
    logic        [18:0] dv_sh;
    logic               dv_ge;
    logic        [16:0] s_abs;
    logic signed [65:0] sum;
    logic signed [43:0] wide;
    logic        [32:0] m_abs;
    logic        [25:0] lq_raw;
    logic        [31:0] ph_new;
    logic               in_xfer, load_out;

    assign in_xfer  = i_smp.valid && i_smp.ready;
    assign load_out = (r_state == S_FIN) && (!r_ov || o_res.ready);

    assign i_smp.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.local_sine  = r_o_sine;
    assign o_res.phase_out   = r_o_phase;
    assign o_res.increment_out = r_o_inc;
    assign o_res.lock_quality  = r_o_lock;

    // Sample alignment to Q1.15
    assign smp_ext = EXT_W'(i_smp.sample);
    assign smp_al  = (smp_ext >>> SHR) <<< SHL;

    // Sine argument: current phase, plus a quarter turn for the cosine pass
    assign ang  = (32'(r_phase) << PH_LO) + ((r_pc >= 4'd5) ? 32'h4000_0000 : 32'd0);
    assign quad = ang[31:30];
    assign xf   = quad[0] ? (31'h4000_0000 - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};

    // Sine rounding, clip and sign
    assign y_rnd  = {1'b0, r_prod[61:30]} + 33'd16384;
    assign y_q    = y_rnd[32:15];
    assign y_clip = (y_q > 18'd32767) ? 15'h7FFF : y_q[14:0];
    assign y_sgn  = quad[1] ? -$signed({1'b0, y_clip}) : $signed({1'b0, y_clip});

    // Root step
    assign rt_try = r_res + r_bit;
    assign rt_ge  = (r_sv >= rt_try);

    // Divider step
    assign dv_sh = {r_rem, r_dq[31]};
    assign dv_ge = (dv_sh >= {1'b0, r_dvs});

    assign s_abs = r_s[15] ? 17'(-{r_s[15], r_s}) : {1'b0, r_s};

    // Sequencer and datapath
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        n_integ  = r_integ;
        n_loud   = r_loud;
        n_match  = r_match;
        n_s      = r_s;
        n_x      = r_x;
        n_x2     = r_x2;
        n_mine   = r_mine;
        n_across = r_across;
        n_acc    = r_acc;
        n_sv     = r_sv;
        n_res    = r_res;
        n_bit    = r_bit;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_dq     = r_dq;
        n_held   = r_held;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_e      = r_e;
        n_xm     = r_xm;
        n_ti     = r_ti;
        n_tf     = r_tf;
        n_inc    = r_inc;
        n_p_sine = r_p_sine;
        n_p_phase = r_p_phase;
        n_p_inc  = r_p_inc;
        n_p_lock = r_p_lock;
        mul_a    = '0;
        mul_b    = '0;
        sum      = '0;
        wide     = '0;
        m_abs    = '0;
        lq_raw   = '0;
        ph_new   = '0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_s  = smp_al[15:0];
                    n_pc = '0;
                    if (r_enabled) begin
                        n_state = S_PRE;
                    end else begin
                        n_p_sine  = '0;
                        n_p_phase = '0;
                        n_p_inc   = '0;
                        n_p_lock  = '0;
                        n_state   = S_FIN;
                    end
                end
            end

            // Sine, cosine and loudness
            S_PRE: begin
                n_pc = r_pc + 4'd1;
                case (r_pc)
                    4'd0, 4'd5: begin
                        n_x   = xf;
                        mul_a = $signed(33'(xf));
                        mul_b = $signed(33'(xf));
                    end
                    4'd1, 4'd6: begin
                        n_x2  = r_prod[60:30];
                        mul_a = $signed(33'(r_prod[60:30]));
                        mul_b = $signed(33'(SIN_C));
                    end
                    4'd2, 4'd7: begin
                        mul_a = $signed(33'(r_x2));
                        mul_b = $signed(33'(SIN_B - r_prod[61:30]));
                    end
                    4'd3, 4'd8: begin
                        mul_a = $signed(33'(r_x));
                        mul_b = $signed(33'(SIN_A - r_prod[61:30]));
                    end
                    4'd4: begin
                        n_mine = y_sgn;
                    end
                    4'd9: begin
                        n_across = y_sgn;
                    end
                    4'd10: begin
                        mul_a = 33'(r_s);
                        mul_b = 33'(r_s);
                    end
                    4'd11: begin
                        mul_a = $signed(33'(17'h10000 - {1'b0, r_level_keep}));
                        mul_b = $signed(33'(r_prod[30:0]));
                    end
                    4'd12: begin
                        n_acc = r_prod;
                        mul_a = $signed(33'(r_level_keep));
                        mul_b = $signed(33'(r_loud));
                    end
                    4'd13: begin
                        sum    = r_acc + r_prod;
                        n_loud = sum[47:16];
                        n_sv   = {2'b0, sum[47:16], 1'b0} + 35'(r_loud_floor);
                        n_res  = '0;
                        n_bit  = 35'h4_0000_0000;
                        n_state = S_ROOT;
                    end
                    default: begin
                        n_state = S_ROOT;
                    end
                endcase
            end

            // Integer square root, two bits of radicand per cycle
            S_ROOT: begin
                if (rt_ge) begin
                    n_sv  = r_sv - rt_try;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_dvs   = (n_res == '0) ? 18'd1 : n_res[17:0];
                    n_dq    = {s_abs[15:0], 16'b0} | {s_abs[16], 31'b0};
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end

            // Restoring divide, one quotient bit per cycle
            S_DIV: begin
                if (dv_ge) begin
                    n_rem = 18'(dv_sh - {1'b0, r_dvs});
                end else begin
                    n_rem = dv_sh[17:0];
                end
                n_dq  = {r_dq[30:0], dv_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    if (n_dq > HELD_LIMIT) begin
                        n_held = r_s[15] ? -24'sd4194304 : 24'sd4194304;
                    end else begin
                        n_held = r_s[15] ? -$signed(24'(n_dq)) : $signed(24'(n_dq));
                    end
                    n_pc    = '0;
                    n_state = S_POST;
                end
            end

            // Phase error, loop filter, lock measure
            S_POST: begin
                n_pc = r_pc + 4'd1;
                case (r_pc)
                    4'd0: begin
                        mul_a = 33'(r_held);
                        mul_b = 33'(r_across);
                    end
                    4'd1: begin
                        n_neg = r_prod[65];
                        n_mag = r_prod[65] ? 37'(-r_prod) : r_prod[36:0];
                        mul_a = 33'(r_held);
                        mul_b = 33'(r_mine);
                    end
                    4'd2: begin
                        n_xm  = r_prod[38:7];
                        mul_a = $signed(33'(INV_PI_Q32));
                        mul_b = $signed(33'(r_mag[36:16]));
                    end
                    4'd3: begin
                        n_acc = r_prod;
                        mul_a = $signed(33'(INV_PI_Q32));
                        mul_b = $signed(33'(r_mag[15:0]));
                    end
                    4'd4: begin
                        sum   = r_acc + (r_prod >>> 16);
                        n_e   = sum[52:16];
                        mul_a = $signed(33'(r_match_keep));
                        mul_b = 33'(r_match);
                    end
                    4'd5: begin
                        n_acc = r_prod;
                        mul_a = $signed(33'(17'h10000 - {1'b0, r_match_keep}));
                        mul_b = 33'(r_xm);
                    end
                    4'd6: begin
                        sum     = r_acc + r_prod;
                        n_match = sum[47:16];
                        mul_a   = $signed(33'(r_slow_gain));
                        mul_b   = $signed(33'(r_e[36:16]));
                    end
                    4'd7: begin
                        n_acc = r_prod;
                        mul_a = $signed(33'(r_slow_gain));
                        mul_b = $signed(33'(r_e[15:0]));
                    end
                    4'd8: begin
                        sum   = r_acc + (r_prod >>> 16);
                        n_ti  = sum[56:15];
                        mul_a = $signed(33'(r_fast_gain));
                        mul_b = $signed(33'(r_e[36:16]));
                    end
                    4'd9: begin
                        n_acc = r_prod;
                        mul_a = $signed(33'(r_fast_gain));
                        mul_b = $signed(33'(r_e[15:0]));
                    end
                    4'd10: begin
                        sum  = r_acc + (r_prod >>> 16);
                        n_tf = sum[54:13];
                        wide = r_neg ? 44'(r_integ) - $signed({2'b0, r_ti})
                                     : 44'(r_integ) + $signed({2'b0, r_ti});
                        n_integ = sat32(wide);
                    end
                    4'd11: begin
                        wide = $signed(44'(r_base_step)) + 44'(r_integ);
                        wide = r_neg ? wide - $signed({2'b0, r_tf})
                                     : wide + $signed({2'b0, r_tf});
                        n_inc = sat32(wide);
                    end
                    4'd12: begin
                        n_phase   = r_phase + r_inc[31 -: PHASE_WIDTH];
                        ph_new    = 32'(n_phase) << PH_LO;
                        m_abs     = r_match[31] ? 33'(-{r_match[31], r_match})
                                                : {1'b0, r_match};
                        lq_raw    = m_abs[32:7];
                        n_p_sine  = r_mine;
                        n_p_phase = ph_new;
                        n_p_inc   = r_inc;
                        n_p_lock  = (lq_raw > 26'd65535) ? 16'hFFFF : lq_raw[15:0];
                        n_state   = S_FIN;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end

            S_FIN: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control, configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pc         <= '0;
            r_cnt        <= '0;
            r_ov         <= 1'b0;
            r_enabled    <= 1'b0;
            r_base_step  <= '0;
            r_fast_gain  <= '0;
            r_slow_gain  <= '0;
            r_level_keep <= KEEP_RESET;
            r_match_keep <= KEEP_RESET;
            r_loud_floor <= FLOOR_RESET;
            r_phase      <= '0;
            r_integ      <= '0;
            r_loud       <= '0;
            r_match      <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
            r_integ <= n_integ;
            r_loud  <= n_loud;
            r_match <= n_match;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLED:    r_enabled    <= i_cfg_data[0];
                    CFG_BASE_STEP:  r_base_step  <= i_cfg_data[30:0];
                    CFG_FAST_GAIN:  r_fast_gain  <= i_cfg_data;
                    CFG_SLOW_GAIN:  r_slow_gain  <= i_cfg_data;
                    CFG_LEVEL_KEEP: r_level_keep <= i_cfg_data[15:0];
                    CFG_MATCH_KEEP: r_match_keep <= i_cfg_data[15:0];
                    CFG_LOUD_FLOOR: r_loud_floor <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod    <= mul_a * mul_b;
        r_acc     <= n_acc;
        r_s       <= n_s;
        r_x       <= n_x;
        r_x2      <= n_x2;
        r_mine    <= n_mine;
        r_across  <= n_across;
        r_sv      <= n_sv;
        r_res     <= n_res;
        r_bit     <= n_bit;
        r_rem     <= n_rem;
        r_dvs     <= n_dvs;
        r_dq      <= n_dq;
        r_held    <= n_held;
        r_neg     <= n_neg;
        r_mag     <= n_mag;
        r_e       <= n_e;
        r_xm      <= n_xm;
        r_ti      <= n_ti;
        r_tf      <= n_tf;
        r_inc     <= n_inc;
        r_p_sine  <= n_p_sine;
        r_p_phase <= n_p_phase;
        r_p_inc   <= n_p_inc;
        r_p_lock  <= n_p_lock;
        if (load_out) begin
            r_o_sine  <= r_p_sine;
            r_o_phase <= r_p_phase;
            r_o_inc   <= r_p_inc;
            r_o_lock  <= r_p_lock;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ttp_chk.sv
`default_nettype none

module ttp_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_out_phase,
    input wire [31:0] i_out_inc
);

    // A result offered stays offered until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    // A stalled result keeps its phase and increment
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_phase) && $stable(i_out_inc)))
        else $error("stalled result changed");

    // The block is busy right after taking a sample
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("sample taken while busy");

    // Reset leaves the block idle with no result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("not idle after reset");

    // A new result appears only as the block returns to idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result loaded while busy");

endmodule

bind tone_tracking_pll_top ttp_chk u_ttp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_phase (o_res.phase_out),
    .i_out_inc   (o_res.increment_out)
);

`default_nettype wire

// File: tb/tone_tracking_pll_checker.sv
`timescale 1ns / 100ps

// Watches the config port and both channels, predicts each result and compares
module tone_tracking_pll_checker
    import ttp_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    ttp_in_if                    smp_mon,
    ttp_out_if                   res_mon,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic signed [15:0] sine;
        logic        [31:0] phase;
        logic signed [31:0] incr;
        logic        [15:0] lock;
    } pll_result_t;

    // Loop settings
    logic        en;
    logic [30:0] base_step;
    logic [31:0] fast_gain, slow_gain;
    logic [15:0] level_keep, match_keep, loud_floor;

    // Loop state
    logic        [31:0] phase_acc, loud_acc;
    logic signed [31:0] integ_acc, match_acc;

    pll_result_t expected_results[$];
    int          mismatches;

    function automatic logic signed [15:0] poly_sine(input logic [31:0] ph);
        logic [63:0] x, x2, t, y;
        x = {34'd0, ph[29:0]};
        if (ph[30]) x = 64'd1073741824 - x;
        x2 = (x * x) >> 30;
        t = 64'(SIN_B) - ((x2 * 64'(SIN_C)) >> 30);
        t = 64'(SIN_A) - ((x2 * t) >> 30);
        y = (x * t) >> 30;
        y = (y + 64'd16384) >> 15;
        if (y > 64'd32767) y = 64'd32767;
        return ph[31] ? -16'(y) : 16'(y);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 34;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // (g * e) >> (16 + k), the product split across the halves of e
    function automatic logic [63:0] split_mul(input logic [63:0] g, input logic [63:0] e,
                                              input int k);
        return (g * (e >> 16) + ((g * (e & 64'hFFFF)) >> 16)) >> k;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // One loop update; advances the state copy
    task automatic track_sample(input logic signed [15:0] smp, output pll_result_t r);
        logic signed [63:0] s, held, prod, x, m, step, lq, across, mine;
        logic        [63:0] root, mag, e, ti, tf;
        logic               neg;
        if (!en) begin
            r = '0;
            return;
        end
        s = smp;
        mine = poly_sine(phase_acc);
        across = poly_sine(phase_acc + 32'h40000000);
        loud_acc = 32'((64'(level_keep) * 64'(loud_acc)
                        + 64'(17'd65536 - level_keep) * 64'(s * s)) >> 16);
        root = int_sqrt(2 * 64'(loud_acc) + 64'(loud_floor));
        if (root == 0) root = 1;
        mag = (64'(s < 0 ? -s : s) << 16) / root;
        held = mag;
        if (held > 64'sd4194304) held = 64'(HELD_LIMIT);
        if (s < 0) held = -held;
        prod = held * across;
        neg = prod < 0;
        e = split_mul(64'(INV_PI_Q32), neg ? -prod : prod, 16);
        ti = split_mul(64'(slow_gain), e, 15);
        tf = split_mul(64'(fast_gain), e, 13);
        x = (held * mine) >>> 7;
        m = (64'(match_keep) * 64'(match_acc) + 64'(17'd65536 - match_keep) * x) >>> 16;
        match_acc = m[31:0];
        integ_acc = clip32(64'(integ_acc) + (neg ? -64'(ti) : 64'(ti)));
        step = 64'(base_step) + 64'(integ_acc) + (neg ? -64'(tf) : 64'(tf));
        r.incr = clip32(step);
        phase_acc = phase_acc + r.incr;
        lq = (2 * (match_acc < 0 ? -64'(match_acc) : 64'(match_acc))) >>> 8;
        if (lq > 65535) lq = 65535;
        r.sine = mine[15:0];
        r.phase = phase_acc;
        r.lock = lq[15:0];
    endtask

    task automatic report(input string fld, input logic [31:0] want, input logic [31:0] got);
        o_fail_count++;
        if (mismatches < 10)
            $display("%t mismatch %s: expected %h, got %h", $realtime, fld, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        pll_result_t want, got;
        if (!i_rst_n) begin
            en = 0; base_step = 0; fast_gain = 0; slow_gain = 0;
            level_keep = KEEP_RESET; match_keep = KEEP_RESET; loud_floor = FLOOR_RESET;
            phase_acc = 0; integ_acc = 0; loud_acc = 0; match_acc = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLED:    en = i_cfg_data[0];
                    CFG_BASE_STEP:  base_step = i_cfg_data[30:0];
                    CFG_FAST_GAIN:  fast_gain = i_cfg_data;
                    CFG_SLOW_GAIN:  slow_gain = i_cfg_data;
                    CFG_LEVEL_KEEP: level_keep = i_cfg_data[15:0];
                    CFG_MATCH_KEEP: match_keep = i_cfg_data[15:0];
                    CFG_LOUD_FLOOR: loud_floor = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // result transfer: compare against oldest expectation
            if (res_mon.valid && res_mon.ready) begin
                got = {res_mon.local_sine, res_mon.phase_out,
                       res_mon.increment_out, res_mon.lock_quality};
                if (expected_results.size() == 0) begin
                    report("unexpected result", '0, got.phase);
                end else begin
                    want = expected_results.pop_front();
                    if (got.sine !== want.sine) report("local_sine", want.sine, got.sine);
                    if (got.phase !== want.phase) report("phase_out", want.phase, got.phase);
                    if (got.incr !== want.incr) report("increment_out", want.incr, got.incr);
                    if (got.lock !== want.lock) report("lock_quality", want.lock, got.lock);
                end
            end
            // sample transfer
            if (smp_mon.valid && smp_mon.ready) begin
                track_sample(smp_mon.sample, want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        mismatches = 0;
    end

    // results still owed at the end count as failures
    function automatic int leftover();
        return expected_results.size();
    endfunction

endmodule

// File: tb/tb_tone_tracking_pll_top.sv
`timescale 1ns / 100ps

module tb_tone_tracking_pll_top;
    import ttp_pkg::*;

    localparam int  WATCHDOG_LIMIT = 3000;
    localparam real TWO_PI = 6.28318530717958647692;

    // index past the last register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles;
    int                    out_stall;

    ttp_in_if  #(.SAMPLE_WIDTH(16)) smp_ch ();
    ttp_out_if                      res_ch ();

    tone_tracking_pll_top #(.SAMPLE_WIDTH(16), .PHASE_WIDTH(32)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp_ch),
        .o_res      (res_ch)
    );

    tone_tracking_pll_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .smp_mon      (smp_ch),
        .res_mon      (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // result side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            out_stall <= 0;
        end else if (out_stall > 0) begin
            res_ch.ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else if ($urandom_range(3) == 0) begin
            res_ch.ready <= 1'b0;
            out_stall <= pick_gap();
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_tone_tracking_pll_top: FAIL");
            $finish;
        end
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic en, input logic [31:0] fstep, input logic [31:0] fast,
                             input logic [31:0] slow, input logic [15:0] lkeep,
                             input logic [15:0] mkeep, input logic [15:0] flr);
        reg_write(CFG_BASE_STEP, fstep);
        reg_write(CFG_FAST_GAIN, fast);
        reg_write(CFG_SLOW_GAIN, slow);
        reg_write(CFG_LEVEL_KEEP, {$urandom} & 32'hFFFF0000 | 32'(lkeep));
        reg_write(CFG_MATCH_KEEP, 32'(mkeep));
        reg_write(CFG_LOUD_FLOOR, 32'(flr));
        reg_write(CFG_ENABLED, {31'd0, en});
        cfg_we <= 1'b0;
    endtask

    // wait for every result, then let the block settle before touching settings
    task automatic drain();
        smp_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one sample transfer; valid stays high afterwards so back-to-back needs no toggle
    task automatic send(input logic signed [15:0] s, input int gap);
        if (gap > 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_ch.valid <= 1'b1;
        smp_ch.sample <= s;
        forever begin
            @(negedge i_clk);
            if (smp_ch.ready) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    // random part: mostly tones near the loop's rate, the rest noise
    task automatic random_run(input int count, input logic [31:0] fstep);
        real  freq, amp, ph;
        logic signed [15:0] s;
        int   left;
        ph = 0.0;
        freq = (real'(fstep) / 4294967296.0) * (0.9 + 0.2 * real'($urandom_range(1000)) / 1000.0);
        amp = real'($urandom_range(32767, 100));
        left = 0;
        for (int i = 0; i < count; i++) begin
            if (left == 0) begin
                left = $urandom_range(60, 10);
                amp = real'($urandom_range(32767, 50));
                if ($urandom_range(3) == 0) freq = real'($urandom_range(5000)) / 10000.0;
            end
            left--;
            if ($urandom_range(9) < 7) begin
                s = 16'($rtoi(amp * $sin(TWO_PI * ph)));
                s = s ^ 16'($urandom_range(3));
            end else begin
                s = 16'($urandom);
            end
            ph = ph + freq;
            if (ph >= 1.0) ph = ph - 1.0;
            send(s, pick_gap());
            if (i == count / 2 && $urandom_range(1) == 0) drain();
        end
    endtask

    logic [31:0] rs;

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        smp_ch.valid = 1'b0;
        smp_ch.sample = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: loop off, results all zero
        send(16'sh7FFF, 0);
        send(-16'sh8000, 0);
        send(16'sh0000, 2);

        // directed: extremes of the sample and the zero root
        drain();
        write_all(1'b1, 32'd89478485, 32'h1000_0000, 32'h0040_0000, 16'd65471, 16'd65471, 16'd1);
        send(16'sh7FFF, 0);
        send(-16'sh8000, 0);
        send(16'sh0000, 0);
        send(-16'sh0001, 1);
        send(16'sh0001, 0);
        send(16'sh5555, 0);
        send(16'shAAAA, 3);
        send(16'sh7FFF, 0);
        send(16'sh7FFF, 0);
        drain();
        write_all(1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0);
        reg_write(CFG_NO_REG, 32'hFFFF_FFFF);
        cfg_we <= 1'b0;
        send(16'sh0000, 0);
        send(16'sh0000, 0);
        send(-16'sh8000, 0);
        send(16'sh7FFF, 0);
        send(16'sh0000, 1);

        // nominal loop, tracking tones
        drain();
        write_all(1'b1, 32'd89478485, 32'h1000_0000, 32'h0040_0000, 16'd65471, 16'd65471, 16'd1);
        random_run(200, 32'd89478485);
        drain();
        send(16'sh1234, 0);

        // all registers at their top
        drain();
        write_all(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF);
        random_run(100, 32'h7FFF_FFFF);

        // all registers at their bottom
        drain();
        write_all(1'b1, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        random_run(150, 32'd1000000);

        // random settings
        for (int p = 0; p < 3; p++) begin
            drain();
            rs = $urandom;
            write_all(1'b1, rs, $urandom, $urandom >> $urandom_range(31), 16'($urandom),
                      16'($urandom), 16'($urandom));
            random_run(150, rs & 32'h7FFF_FFFF);
        end

        // loop off with state held, then back on
        drain();
        write_all(1'b0, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'd7);
        random_run(80, 32'd50000000);
        drain();
        reg_write(CFG_ENABLED, 32'd1);
        cfg_we <= 1'b0;
        random_run(120, 32'd50000000);

        // slow gains, long settle
        drain();
        write_all(1'b1, 32'd178956970, 32'h0400_0000, 32'h0010_0000, 16'd65000, 16'd65500,
                  16'd1);
        random_run(130, 32'd178956970);

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && u_checker.leftover() == 0) begin
            $display("tb_tone_tracking_pll_top: PASS");
        end else begin
            $display("tb_tone_tracking_pll_top: FAIL");
        end
        $finish;
    end

endmodule
